### hdl/cfas_pkg.sv
// ----------------------------------------------------------------------------
// cfas_pkg: shared constants for the context feature argmax scorer
// Action codes, default sizes and the sigmoid knot table.
// ----------------------------------------------------------------------------
package cfas_pkg;

  localparam int unsigned VocabDefault   = 4096;
  localparam int unsigned DimDefault     = 10;
  localparam int unsigned ContextDefault = 1024;

  localparam int unsigned TokW   = 12;
  localparam int unsigned ElemW  = 4;
  localparam int unsigned ValW   = 16;
  localparam int unsigned CountW = 13;
  localparam int unsigned ScoreW = 37;
  localparam int unsigned ActW   = 2;

  typedef enum logic [ActW-1:0] {
    ACT_LOAD = 2'd0,
    ACT_PUSH = 2'd1,
    ACT_GEN  = 2'd2,
    ACT_NOP  = 2'd3
  } action_e;

  // Sigmoid knots, round(65536*sigmoid(k)) for k = -8..8
  function automatic logic [16:0] sig_point(input logic [4:0] k);
    logic [16:0] r;
    begin
      case (k)
        5'd0:  r = 17'd22;
        5'd1:  r = 17'd60;
        5'd2:  r = 17'd162;
        5'd3:  r = 17'd439;
        5'd4:  r = 17'd1179;
        5'd5:  r = 17'd3108;
        5'd6:  r = 17'd7812;
        5'd7:  r = 17'd17625;
        5'd8:  r = 17'd32768;
        5'd9:  r = 17'd47911;
        5'd10: r = 17'd57724;
        5'd11: r = 17'd62428;
        5'd12: r = 17'd64357;
        5'd13: r = 17'd65097;
        5'd14: r = 17'd65374;
        5'd15: r = 17'd65476;
        default: r = 17'd65514;
      endcase
      return r;
    end
  endfunction

endpackage

### hdl/context_feature_argmax_scorer_top.sv
// ----------------------------------------------------------------------------
// context_feature_argmax_scorer_top: context feature argmax scorer
// Load/push requests write memories; a generate request accumulates context
// features, passes them through a sigmoid and scans the vocabulary.
// ----------------------------------------------------------------------------
// Load, push: taken back to back; no result.
// Generate: a context pass, a sigmoid pass and a vocabulary scan to the result,
//   with one table element per memory access.
// A waiting result holds only a further generate, in its last state.
// Reset clears control, fill count, ring pointer and vocab_count; memories
//   are left unset, and no clearing pass runs.
module context_feature_argmax_scorer_top #(
  parameter int unsigned VOCAB   = cfas_pkg::VocabDefault,
  parameter int unsigned DIM     = cfas_pkg::DimDefault,
  parameter int unsigned CONTEXT = cfas_pkg::ContextDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,      // vocab_count
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [1:0] action, [13:2] token_index, [17:14] element_index,
  // [33:18] vector_value, [49:34] weight_value, [55:50] zero
  input  logic [55:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [11:0] next_token, [48:12] best_score, [49] empty_vocab, [55:50] zero
  output logic [55:0] m_axis_tdata_o
);
  import cfas_pkg::*;

  localparam int unsigned DepthT = VOCAB * DIM;
  localparam int unsigned AddrW  = $clog2(DepthT);
  localparam int unsigned DimW   = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int unsigned DimCW  = $clog2(DIM + 1);
  localparam int unsigned CtxW   = (CONTEXT > 1) ? $clog2(CONTEXT) : 1;
  localparam int unsigned FillW  = $clog2(CONTEXT + 1);
  localparam int unsigned VocW   = $clog2(VOCAB + 1);
  localparam int unsigned SumW   = 32 + FillW + 1;
  localparam int unsigned AccW   = 34 + DimCW + 1;
  localparam int unsigned ScanLim = (VOCAB < 4096) ? VOCAB : 4096;

  // State codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CRD   = 4'd1;  // read ring entry
  localparam logic [3:0] S_CWT   = 4'd2;  // ring data returns
  localparam logic [3:0] S_TRD   = 4'd3;  // read table element
  localparam logic [3:0] S_TWT   = 4'd4;  // table data returns
  localparam logic [3:0] S_MAC   = 4'd5;  // multiply result added
  localparam logic [3:0] S_SIG   = 4'd6;  // sigmoid of one feature
  localparam logic [3:0] S_SRD   = 4'd7;  // scan: read element
  localparam logic [3:0] S_SWT   = 4'd8;
  localparam logic [3:0] S_SMAC  = 4'd9;
  localparam logic [3:0] S_CMP   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;
  localparam logic [3:0] S_SIGM  = 4'd12;  // sigmoid interpolation added and stored

  // Memories
  logic [ValW-1:0] vec_mem [DepthT];
  logic [ValW-1:0] wgt_mem [DepthT];
  logic [TokW-1:0] ring_mem [CONTEXT];
  logic [ValW-1:0] vec_rd_q, wgt_rd_q;
  logic [TokW-1:0] ring_rd_q;

  logic [3:0]        state_q, state_d;
  logic [CountW-1:0] vocab_count_q;
  logic [FillW-1:0]  fill_q;
  logic [CtxW-1:0]   ptr_q;
  logic [FillW-1:0]  ci_q;          // context index
  logic [TokW-1:0]   ctok_q;
  logic [DimW-1:0]   j_q;
  logic [VocW-1:0]   vi_q;          // vocab index
  logic [VocW-1:0]   cnt_q;
  logic signed [SumW-1:0] fsum_q [DIM];
  logic [16:0]       h_q [DIM];
  logic signed [31:0] prod_q;
  logic signed [AccW-1:0] acc_q, best_q;
  logic [TokW-1:0]   best_idx_q;
  logic              first_q;
  logic [41:0]       sig_mul_q;
  logic [16:0]       sig_base_q;
  logic              out_v_q;
  logic [55:0]       out_q;

  // Unpack request
  logic [ActW-1:0]  act;
  logic [TokW-1:0]  tok;
  logic [ElemW-1:0] elem;
  logic [ValW-1:0]  vin, win;
  assign act  = s_axis_tdata_i[1:0];
  assign tok  = s_axis_tdata_i[13:2];
  assign elem = s_axis_tdata_i[17:14];
  assign vin  = s_axis_tdata_i[33:18];
  assign win  = s_axis_tdata_i[49:34];

  logic acc_in;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign acc_in = s_axis_tvalid_i && s_axis_tready_o;

  // Output register free for a new result in this cycle
  logic out_free;
  assign out_free = !out_v_q || m_axis_tready_i;

  // Addressing
  logic [AddrW-1:0] ctx_addr, scan_addr, load_addr;
  assign ctx_addr  = AddrW'(ctok_q * DIM + j_q);
  assign scan_addr = AddrW'(vi_q * DIM + j_q);
  assign load_addr = AddrW'(tok * DIM + elem);

  logic load_ok;
  assign load_ok = acc_in && act == ACT_LOAD && (tok < VOCAB) && (elem < DIM);

  // Append path: push request or generate winner
  logic            app_en;
  logic [TokW-1:0] app_tok;
  assign app_en  = (acc_in && act == ACT_PUSH) ||
                   (state_q == S_OUT && out_free && cnt_q != '0);
  assign app_tok = (state_q == S_OUT) ? best_idx_q : tok;

  // Table memories: one write, one read per cycle
  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      vec_mem[load_addr] <= vin;
      wgt_mem[load_addr] <= win;
    end
    if (state_q == S_TRD) begin
      vec_rd_q <= vec_mem[ctx_addr];
      wgt_rd_q <= wgt_mem[ctx_addr];
    end else begin
      vec_rd_q <= vec_mem[scan_addr];
      wgt_rd_q <= wgt_mem[scan_addr];
    end
  end

  // Ring memory
  always_ff @(posedge clk_i) begin
    if (app_en) ring_mem[ptr_q] <= app_tok;
    ring_rd_q <= ring_mem[ci_q[CtxW-1:0]];
  end

  // Sigmoid operand of the current feature
  logic signed [SumW-1:0] fsel;
  logic signed [SumW:0]   uval;
  logic [4:0]             seg;
  logic [23:0]            frac;
  logic                   top_hit;
  assign fsel = fsum_q[j_q];
  always_comb begin
    if (fsel < -$signed({{(SumW-28){1'b0}}, 28'h8000000}))
      uval = '0;
    else if (fsel > $signed({{(SumW-28){1'b0}}, 28'h8000000}))
      uval = (SumW+1)'(29'h10000000);
    else
      uval = (SumW+1)'(fsel) + (SumW+1)'(29'h08000000);
    seg     = uval[28:24];
    frac    = uval[23:0];
    top_hit = seg[4];
  end

  logic [16:0] p0, p1;
  assign p0 = sig_point(seg);
  assign p1 = sig_point(seg + 5'd1);

  // Context product, dropped for a token outside the vocabulary
  logic signed [SumW-1:0] mac_term;
  assign mac_term = (ctok_q < VOCAB) ? SumW'(prod_q) : '0;

  logic signed [AccW-1:0] acc_next;
  assign acc_next = acc_q + AccW'(prod_q);

  logic [CountW-1:0] cnt_sat;
  assign cnt_sat = (vocab_count_q > CountW'(ScanLim)) ? CountW'(ScanLim) : vocab_count_q;

  // Control and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      vocab_count_q <= '0;
      fill_q        <= '0;
      ptr_q         <= '0;
      out_v_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) vocab_count_q <= cfg_wdata_i;
      if (state_q == S_OUT && out_free) out_v_q <= 1'b1;
      else if (m_axis_tready_i) out_v_q <= 1'b0;
      if (app_en) begin
        ptr_q <= (ptr_q == CtxW'(CONTEXT - 1)) ? '0 : ptr_q + 1'b1;
        if (fill_q != FillW'(CONTEXT)) fill_q <= fill_q + 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (acc_in && act == ACT_GEN) begin
          for (int k = 0; k < DIM; k++) fsum_q[k] <= '0;
          ci_q  <= '0;
          j_q   <= '0;
          cnt_q <= VocW'(cnt_sat);
        end
      end
      S_CRD: ;
      S_CWT: begin
        ctok_q <= ring_rd_q;
        j_q    <= '0;
      end
      S_TRD: ;
      S_TWT: prod_q <= $signed(vec_rd_q) * $signed(wgt_rd_q);
      S_MAC: begin
        fsum_q[j_q] <= fsel + mac_term;
        if (j_q == DimW'(DIM - 1)) begin
          j_q  <= '0;
          ci_q <= ci_q + 1'b1;
        end else begin
          j_q <= j_q + 1'b1;
        end
      end
      S_SIG: begin
        sig_base_q <= p0;
        sig_mul_q  <= top_hit ? '0 : (p1 - p0) * frac;
      end
      S_SIGM: begin
        h_q[j_q] <= sig_base_q + 17'(sig_mul_q >> 24);
        if (j_q == DimW'(DIM - 1)) begin
          j_q   <= '0;
          vi_q  <= '0;
          acc_q <= '0;
          first_q <= 1'b1;
        end else begin
          j_q <= j_q + 1'b1;
        end
      end
      S_SRD: ;
      S_SWT: prod_q <= $signed({1'b0, h_q[j_q]}) * $signed(vec_rd_q);
      S_SMAC: begin
        acc_q <= acc_next;
        if (j_q == DimW'(DIM - 1)) j_q <= '0;
        else j_q <= j_q + 1'b1;
      end
      S_CMP: begin
        if (first_q || acc_q > best_q) begin
          best_q     <= acc_q;
          best_idx_q <= TokW'(vi_q);
        end
        first_q <= 1'b0;
        acc_q   <= '0;
        vi_q    <= vi_q + 1'b1;
      end
      S_OUT: begin
        // Hold the result until the output register frees
        if (out_free) begin
          if (cnt_q == '0) begin
            out_q <= {6'd0, 1'b1, 37'd0, 12'd0};
          end else if (best_q > $signed(AccW'(37'h0FFFFFFFFF))) begin
            out_q <= {6'd0, 1'b0, 37'h0FFFFFFFFF, best_idx_q};
          end else if (best_q < -$signed(AccW'(37'h1000000000))) begin
            out_q <= {6'd0, 1'b0, 37'h1000000000, best_idx_q};
          end else begin
            out_q <= {6'd0, 1'b0, best_q[36:0], best_idx_q};
          end
        end
      end
      default: ;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (acc_in && act == ACT_GEN) state_d = (fill_q != '0) ? S_CRD : S_SIG;
      S_CRD:  state_d = S_CWT;
      S_CWT:  state_d = (ring_rd_q < VOCAB) ? S_TRD : S_MAC;
      S_TRD:  state_d = S_TWT;
      S_TWT:  state_d = S_MAC;
      S_MAC: begin
        if (j_q == DimW'(DIM - 1))
          state_d = (ci_q + 1'b1 == fill_q) ? S_SIG : S_CRD;
        else
          state_d = (ctok_q < VOCAB) ? S_TRD : S_MAC;
      end
      S_SIG:  state_d = S_SIGM;
      S_SIGM: begin
        if (j_q != DimW'(DIM - 1)) state_d = S_SIG;
        else state_d = (cnt_q != '0) ? S_SRD : S_OUT;
      end
      S_SRD:  state_d = S_SWT;
      S_SWT:  state_d = S_SMAC;
      S_SMAC: state_d = (j_q == DimW'(DIM - 1)) ? S_CMP : S_SRD;
      S_CMP:  state_d = (vi_q + 1'b1 == cnt_q) ? S_OUT : S_SRD;
      S_OUT:  state_d = out_free ? S_IDLE : S_OUT;
      default: state_d = S_IDLE;
    endcase
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_q;

  // Assertions
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(CONTEXT)) else $error("fill count above context depth");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !s_axis_tready_o) else $error("request taken while busy");
  a_out_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT |=> out_v_q) else $error("result lost");
  a_ptr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !app_en |=> $stable(ptr_q)) else $error("ring pointer moved");

endmodule

### verif/context_feature_argmax_scorer_checker.sv
// ----------------------------------------------------------------------------
// context_feature_argmax_scorer_checker: scoreboard for the argmax scorer
// Watches the configuration port and both stream channels, keeps its own copy
// of the tables, the context ring and vocab_count, predicts each generate
// result and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module context_feature_argmax_scorer_checker #(
  parameter int unsigned VOCAB   = cfas_pkg::VocabDefault,
  parameter int unsigned DIM     = cfas_pkg::DimDefault,
  parameter int unsigned CONTEXT = cfas_pkg::ContextDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [55:0] s_axis_tdata_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [55:0] m_axis_tdata_i,
  output int          fail_count_o,
  output int          pending_o
);
  import cfas_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [11:0]        next_token;
    logic signed [36:0] best_score;
    logic               empty_vocab;
  } gen_result_t;

  localparam longint SigSpan  = longint'(8) << 24;
  localparam longint ScoreMax = (longint'(1) << 36) - 1;
  localparam longint ScoreMin = -(longint'(1) << 36);
  localparam longint Knots[17] = '{22, 60, 162, 439, 1179, 3108, 7812, 17625, 32768,
                                   47911, 57724, 62428, 64357, 65097, 65374, 65476, 65514};

  logic signed [15:0] vec_mem [VOCAB*DIM];
  logic signed [15:0] wgt_mem [VOCAB*DIM];
  logic [11:0]        ctx_ring [CONTEXT];
  int unsigned        ctx_fill;
  int unsigned        ctx_wp;
  logic [12:0]        vocab_cnt;
  gen_result_t        expected_q[$];
  int                 fail_n = 0;

  assign fail_count_o = fail_n;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_n++;
  endtask

  function automatic longint sigmoid_q16(input longint x);
    longint u;
    longint seg;
    longint frac;
    if (x < -SigSpan) x = -SigSpan;
    if (x > SigSpan) x = SigSpan;
    u = x + SigSpan;
    seg = u >>> 24;
    frac = u & 64'hFF_FFFF;
    if (seg >= 16) return Knots[16];
    return Knots[seg] + (((Knots[seg+1] - Knots[seg]) * frac) >>> 24);
  endfunction

  task automatic ring_append(input logic [11:0] tok);
    ctx_ring[ctx_wp] = tok;
    ctx_wp = (ctx_wp + 1) % CONTEXT;
    if (ctx_fill < CONTEXT) ctx_fill++;
  endtask

  // Accumulate context features, squash them and scan the scored entries
  task automatic predict_next_token();
    longint      feat [DIM];
    longint      score;
    longint      best;
    int unsigned best_idx;
    int unsigned scored;
    gen_result_t r;
    best = 0;
    best_idx = 0;
    for (int j = 0; j < DIM; j++) feat[j] = 0;
    for (int i = 0; i < ctx_fill; i++) begin
      if (ctx_ring[i] < VOCAB) begin
        for (int j = 0; j < DIM; j++)
          feat[j] += longint'(wgt_mem[ctx_ring[i]*DIM+j]) * longint'(vec_mem[ctx_ring[i]*DIM+j]);
      end
    end
    for (int j = 0; j < DIM; j++) feat[j] = sigmoid_q16(feat[j]);
    scored = vocab_cnt;
    if (scored > VOCAB) scored = VOCAB;
    if (scored > 4096) scored = 4096;
    if (scored == 0) begin
      r.next_token = '0;
      r.best_score = '0;
      r.empty_vocab = 1'b1;
    end else begin
      for (int i = 0; i < scored; i++) begin
        score = 0;
        for (int j = 0; j < DIM; j++) score += feat[j] * longint'(vec_mem[i*DIM+j]);
        if (i == 0 || score > best) begin
          best = score;
          best_idx = i;
        end
      end
      ring_append(best_idx[11:0]);
      if (best > ScoreMax) best = ScoreMax;
      if (best < ScoreMin) best = ScoreMin;
      r.next_token = best_idx[11:0];
      r.best_score = best[36:0];
      r.empty_vocab = 1'b0;
    end
    expected_q = {expected_q, r};
  endtask

  // Track configuration and requests, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    gen_result_t want;
    if (!rst_ni) begin
      ctx_fill = 0;
      ctx_wp = 0;
      vocab_cnt = '0;
      expected_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) vocab_cnt = cfg_wdata_i;
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        case (action_e'(s_axis_tdata_i[1:0]))
          ACT_LOAD: begin
            if (s_axis_tdata_i[13:2] < VOCAB && s_axis_tdata_i[17:14] < DIM) begin
              vec_mem[s_axis_tdata_i[13:2]*DIM + s_axis_tdata_i[17:14]] = s_axis_tdata_i[33:18];
              wgt_mem[s_axis_tdata_i[13:2]*DIM + s_axis_tdata_i[17:14]] = s_axis_tdata_i[49:34];
            end
          end
          ACT_PUSH: ring_append(s_axis_tdata_i[13:2]);
          ACT_GEN:  predict_next_token();
          default: ;
        endcase
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_q.size() == 0) begin
          report("unexpected result, next_token", m_axis_tdata_i[11:0], -1);
        end else begin
          want = expected_q.pop_front();
          if (m_axis_tdata_i[11:0] !== want.next_token)
            report("next_token", m_axis_tdata_i[11:0], want.next_token);
          if (m_axis_tdata_i[48:12] !== want.best_score)
            report("best_score", $signed(m_axis_tdata_i[48:12]), want.best_score);
          if (m_axis_tdata_i[49] !== want.empty_vocab)
            report("empty_vocab", m_axis_tdata_i[49], want.empty_vocab);
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

### verif/context_feature_argmax_scorer_top_tb.sv
// ----------------------------------------------------------------------------
// context_feature_argmax_scorer_top_tb: stimulus and verdict for the scorer
// Loads a small working vocabulary, runs directed and random load, push and
// generate requests with random gaps and stalls, including one long hold-off
// on the result side. The checker does all comparison.
// ----------------------------------------------------------------------------
module context_feature_argmax_scorer_top_tb;
  import cfas_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  Dim        = DimDefault;
  localparam int  WorkSet    = 16;
  localparam int  RandItems  = 830;
  localparam int  HoldCycles = 50_000;
  localparam longint CycleLimit = 10_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [12:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  int          fail_count;
  int          pending;
  bit          hold_off_req = 1'b0;
  longint      cycles = 0;

  context_feature_argmax_scorer_top u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready), .s_axis_tdata_i(s_tdata),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready), .m_axis_tdata_o(m_tdata)
  );

  context_feature_argmax_scorer_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_i(s_tready), .s_axis_tdata_i(s_tdata),
    .m_axis_tvalid_i(m_tvalid), .m_axis_tready_i(m_tready), .m_axis_tdata_i(m_tdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Mostly no gap, often a short one, rarely a long one
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one request at the falling edge and hold it until taken
  task automatic send_req(input action_e act, input logic [11:0] tok, input logic [3:0] elem,
                          input logic [15:0] vec, input logic [15:0] wgt);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tdata = {6'b0, wgt, vec, elem, tok, act};
    s_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
  endtask

  task automatic load_entry(input logic [11:0] tok);
    for (int j = 0; j < Dim; j++)
      send_req(ACT_LOAD, tok, j[3:0], 16'($urandom), 16'($urandom));
  endtask

  // Wait for the block to go quiet, then write vocab_count
  task automatic set_vocab_count(input logic [12:0] val);
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    cfg_wdata = val;
    cfg_we = 1'b1;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  function automatic logic [11:0] known_token();
    return ($urandom_range(0, 9) == 0) ? 12'd4095 : 12'($urandom_range(0, WorkSet - 1));
  endfunction

  // Result side: random stalls, calm stretches, and one long hold-off
  initial begin
    int stall;
    int calm;
    bit held;
    stall = 0;
    calm = 0;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !held) begin
        m_tready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        held = 1'b1;
      end
      if (stall > 0) begin
        m_tready = 1'b0;
        stall--;
      end else begin
        m_tready = 1'b1;
        if (calm > 0) calm--;
        else if ($urandom_range(0, 49) == 0) calm = $urandom_range(50, 300);
        else if ($urandom_range(0, 3) == 0) stall = gap_len();
      end
    end
  end

  // Cycle counter and timeout
  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int p;
    logic [11:0] tok;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Working vocabulary, plus the highest token index
    for (int t = 0; t < WorkSet; t++) load_entry(t[11:0]);
    load_entry(12'd4095);
    // Extreme elements: big positive products, big negative ones
    send_req(ACT_LOAD, 12'd0, 4'd0, 16'h7FFF, 16'h7FFF);
    send_req(ACT_LOAD, 12'd1, 4'd9, 16'h8000, 16'h8000);
    send_req(ACT_LOAD, 12'd4, 4'd0, 16'h7FFF, 16'h8000);
    send_req(ACT_LOAD, 12'd4095, 4'd9, 16'h8000, 16'h7FFF);
    // Identical entries 2 and 3 to force a tie, first one wins
    for (int j = 0; j < Dim; j++) begin
      send_req(ACT_LOAD, 12'd2, j[3:0], 16'h0123, 16'h0040);
      send_req(ACT_LOAD, 12'd3, j[3:0], 16'h0123, 16'h0040);
    end

    // Directed part
    set_vocab_count(13'd0);
    send_req(ACT_GEN, 12'd0, 4'd0, 16'h0, 16'h0);          // empty vocabulary, empty context
    set_vocab_count(13'd1);
    send_req(ACT_GEN, 12'd0, 4'd0, 16'h0, 16'h0);
    send_req(ACT_PUSH, 12'd4095, 4'd0, 16'h0, 16'h0);
    send_req(ACT_PUSH, 12'd1, 4'd0, 16'h0, 16'h0);
    send_req(ACT_LOAD, 12'd5, 4'd10, 16'hFFFF, 16'hFFFF);  // dimension out of range
    send_req(ACT_LOAD, 12'd5, 4'd15, 16'hFFFF, 16'hFFFF);
    send_req(ACT_NOP, 12'hFFF, 4'hF, 16'hFFFF, 16'hFFFF);
    send_req(ACT_GEN, 12'd0, 4'd0, 16'h0, 16'h0);
    set_vocab_count(13'd4);                                 // entries 2 and 3 tie
    send_req(ACT_GEN, 12'd0, 4'd0, 16'h0, 16'h0);
    for (int k = 0; k < 6; k++) send_req(ACT_PUSH, 12'd0, 4'd0, 16'h0, 16'h0);
    send_req(ACT_GEN, 12'd0, 4'd0, 16'h0, 16'h0);          // sums beyond the clamp
    for (int k = 0; k < 6; k++) send_req(ACT_PUSH, 12'd4, 4'd0, 16'h0, 16'h0);
    set_vocab_count(13'(WorkSet));
    send_req(ACT_GEN, 12'd0, 4'd0, 16'h0, 16'h0);

    // Random part
    for (int n = 0; n < RandItems; n++) begin
      if (n % 100 == 99)
        set_vocab_count(($urandom_range(0, 7) == 0) ? 13'd0 : 13'($urandom_range(1, WorkSet)));
      if (n == 500) hold_off_req = 1'b1;
      p = $urandom_range(0, 99);
      if (p < 40) begin
        send_req(ACT_LOAD, known_token(), 4'($urandom_range(0, Dim - 1)),
                 16'($urandom), 16'($urandom));
      end else if (p < 55) begin
        send_req(ACT_LOAD, 12'($urandom), 4'($urandom), 16'($urandom), 16'($urandom));
      end else if (p < 75) begin
        tok = known_token();
        send_req(ACT_PUSH, tok, 4'($urandom), 16'($urandom), 16'($urandom));
      end else if (p < 92) begin
        send_req(ACT_GEN, 12'($urandom), 4'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        send_req(ACT_NOP, 12'($urandom), 4'($urandom), 16'($urandom), 16'($urandom));
      end
    end
    s_tvalid = 1'b0;

    // Drain
    while (pending != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
hdl/cfas_pkg.sv
hdl/context_feature_argmax_scorer_top.sv
verif/context_feature_argmax_scorer_checker.sv
verif/context_feature_argmax_scorer_top_tb.sv
